// File: design/hsb_pkg.sv
// ----------------------------------------------------------------------------
// hsb_pkg
// Shared types, constants and the channel fraction table for the HSL
// saturation boost pipeline.
// ----------------------------------------------------------------------------
package hsb_pkg;

    // fraction width defaults and the widest supported fraction
    localparam int FRAC_BITS_DEF = 16;
    localparam int FRAC_BITS_MAX = 24;
    localparam int LUT_W         = FRAC_BITS_MAX + 1;

    // configuration register file
    localparam int          GAIN_W       = 10;
    localparam int          APB_DW       = 32;
    localparam int          APB_AW       = 3;
    localparam logic        REG_GAIN_IDX = 1'b0;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd282;

    // which channel holds the maximum (ties pick red, then green)
    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // pixel payloads
    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       last_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       last_out;
    } t_pix_out;

    typedef logic [255:0][LUT_W-1:0] t_chan_lut;

    // ceil(x * 2^fb / 255) for every byte value, worked out at elaboration
    function automatic t_chan_lut calc_chan_lut(input int fb);
        t_chan_lut lut;
        longint    v;
        for (int x = 0; x < 256; x++) begin
            v = (longint'(x) * (longint'(1) << fb) + 254) / 255;
            lut[x] = LUT_W'(v);
        end
        return lut;
    endfunction

endpackage

// File: design/hsb_front.sv
// ----------------------------------------------------------------------------
// hsb_front
// Front end: channel fractions, max/min search, lightness and the operands
// of the saturation and hue divisions. Three register stages.
// ----------------------------------------------------------------------------
module hsb_front
    import hsb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  t_pix_in              i_pix,
    output logic                 o_valid,
    output logic [FRAC_BITS+1:0] o_a0,
    output logic [FRAC_BITS+1:0] o_b0,
    output logic [FRAC_BITS+1:0] o_a1,
    output logic [FRAC_BITS+1:0] o_b1,
    output logic [FRAC_BITS:0]   o_l,
    output t_sector              o_sector,
    output logic                 o_neg,
    output logic                 o_gray,
    output logic                 o_last
);

    localparam int W  = FRAC_BITS + 1;
    localparam int DW = FRAC_BITS + 2;
    localparam t_chan_lut CH_LUT = calc_chan_lut(FRAC_BITS);
    localparam logic [W-1:0]  HALF    = W'(1) << (FRAC_BITS - 1);
    localparam logic [DW-1:0] TWO_ONE = DW'(1) << (FRAC_BITS + 1);

    // stage 1: byte to fraction
    logic         r_v1;
    logic [W-1:0] r_c [3];
    logic         r_last1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c[0]  <= CH_LUT[i_pix.red_in][W-1:0];
            r_c[1]  <= CH_LUT[i_pix.green_in][W-1:0];
            r_c[2]  <= CH_LUT[i_pix.blue_in][W-1:0];
            r_last1 <= i_pix.last_in;
        end
    end

    // stage 2: max, min, sector and hue numerator
    logic         n_mx, r_v2;
    logic [W-1:0] n_mxv, n_mnv, n_num;
    t_sector      n_sec;
    logic         n_neg;
    logic [W-1:0] w_gb, w_br, w_rg;
    logic [W-1:0] r_mx, r_mn, r_num;
    t_sector      r_sec;
    logic         r_neg, r_last2;

    assign w_gb = (r_c[1] >= r_c[2]) ? r_c[1] - r_c[2] : r_c[2] - r_c[1];
    assign w_br = (r_c[2] >= r_c[0]) ? r_c[2] - r_c[0] : r_c[0] - r_c[2];
    assign w_rg = (r_c[0] >= r_c[1]) ? r_c[0] - r_c[1] : r_c[1] - r_c[0];

    always_comb begin
        n_mx = 1'b0;
        priority if (r_c[0] >= r_c[1] && r_c[0] >= r_c[2]) begin
            n_sec = SEC_RED;
            n_mxv = r_c[0];
            n_num = w_gb;
            n_neg = r_c[1] < r_c[2];
        end else if (r_c[1] >= r_c[2]) begin
            n_sec = SEC_GREEN;
            n_mxv = r_c[1];
            n_num = w_br;
            n_neg = r_c[2] < r_c[0];
        end else begin
            n_sec = SEC_BLUE;
            n_mxv = r_c[2];
            n_num = w_rg;
            n_neg = r_c[0] < r_c[1];
            n_mx  = 1'b1;
        end
        priority if (r_c[0] <= r_c[1] && r_c[0] <= r_c[2]) begin
            n_mnv = r_c[0];
        end else if (r_c[1] <= r_c[2]) begin
            n_mnv = r_c[1];
        end else begin
            n_mnv = r_c[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mx    <= n_mxv;
            r_mn    <= n_mnv;
            r_num   <= n_num;
            r_sec   <= n_sec;
            r_neg   <= n_neg && !(n_mx && 1'b0);
            r_last2 <= r_last1;
        end
    end

    // stage 3: spread, lightness and divisor of the saturation
    logic [DW-1:0] w_sum, w_den;
    logic [W-1:0]  w_l, w_d;
    logic          r_v3;

    assign w_sum = {1'b0, r_mx} + {1'b0, r_mn};
    assign w_l   = w_sum[W:1];
    assign w_d   = r_mx - r_mn;
    assign w_den = (w_l > HALF) ? TWO_ONE - w_sum : w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_a0     <= {1'b0, w_d};
            o_b0     <= w_den;
            o_a1     <= {1'b0, r_num};
            o_b1     <= {1'b0, w_d};
            o_l      <= w_l;
            o_sector <= r_sec;
            o_neg    <= r_neg;
            o_gray   <= (r_mx == r_mn);
            o_last   <= r_last2;
        end
    end

    assign o_valid = r_v3;

endmodule

// File: design/hsb_div_pipe.sv
// ----------------------------------------------------------------------------
// hsb_div_pipe
// Two-lane pipelined restoring divider: q = a * 2^FRAC_BITS / b for a <= b,
// one quotient bit per stage, with a sideband that travels alongside.
// ----------------------------------------------------------------------------
module hsb_div_pipe
    import hsb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SIDE_W    = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [FRAC_BITS+1:0] i_a0,
    input  logic [FRAC_BITS+1:0] i_b0,
    input  logic [FRAC_BITS+1:0] i_a1,
    input  logic [FRAC_BITS+1:0] i_b1,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output logic [FRAC_BITS:0]   o_q0,
    output logic [FRAC_BITS:0]   o_q1,
    output logic [SIDE_W-1:0]    o_side
);

    localparam int NS = FRAC_BITS + 1;
    localparam int DW = FRAC_BITS + 2;

    logic [DW-1:0]     r_rem  [NS][2];
    logic [DW-1:0]     r_div  [NS][2];
    logic [NS-1:0]     r_quo  [NS][2];
    logic [SIDE_W-1:0] r_side [NS];
    logic [NS-1:0]     r_v;

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [DW:0]       w_cand [2];
        logic [DW-1:0]     w_div  [2];
        logic [NS-1:0]     w_quo  [2];
        logic              w_v;
        logic [SIDE_W-1:0] w_side;

        // operands from the port or from the previous stage
        if (k == 0) begin : g_first
            assign w_cand[0] = {1'b0, i_a0};
            assign w_cand[1] = {1'b0, i_a1};
            assign w_div[0]  = i_b0;
            assign w_div[1]  = i_b1;
            assign w_quo[0]  = '0;
            assign w_quo[1]  = '0;
            assign w_v       = i_valid;
            assign w_side    = i_side;
        end else begin : g_next
            for (genvar j = 0; j < 2; j++) begin : g_src
                assign w_cand[j] = {r_rem[k-1][j], 1'b0};
                assign w_div[j]  = r_div[k-1][j];
                assign w_quo[j]  = r_quo[k-1][j];
            end
            assign w_v    = r_v[k-1];
            assign w_side = r_side[k-1];
        end

        // one compare and subtract per lane
        for (genvar j = 0; j < 2; j++) begin : g_lane
            logic        w_bit;
            logic [DW:0] w_diff;

            assign w_bit  = w_cand[j] >= {1'b0, w_div[j]};
            assign w_diff = w_cand[j] - {1'b0, w_div[j]};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_quo[k][j] <= {w_quo[j][NS-2:0], w_bit};
                end
            end

            if (k < NS - 1) begin : g_keep
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[k][j] <= w_bit ? w_diff[DW-1:0] : w_cand[j][DW-1:0];
                        r_div[k][j] <= w_div[j];
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_q0    = r_quo[NS-1][0];
    assign o_q1    = r_quo[NS-1][1];
    assign o_side  = r_side[NS-1];

endmodule

// File: design/hsb_back.sv
// ----------------------------------------------------------------------------
// hsb_back
// Back end: gain on saturation, hue assembly, q/p terms, per-channel
// hue-to-RGB interpolation and conversion to bytes. Six register stages.
// ----------------------------------------------------------------------------
module hsb_back
    import hsb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [GAIN_W-1:0]  i_gain,
    input  logic               i_valid,
    input  logic [FRAC_BITS:0] i_qs,
    input  logic [FRAC_BITS:0] i_qh,
    input  logic [FRAC_BITS:0] i_l,
    input  t_sector            i_sector,
    input  logic               i_neg,
    input  logic               i_gray,
    input  logic               i_last,
    output logic               o_valid,
    output t_pix_out           o_pix
);

    localparam int W  = FRAC_BITS + 1;
    localparam int HW = FRAC_BITS + 3;
    localparam logic [W-1:0]  ONE    = W'(1) << FRAC_BITS;
    localparam logic [W-1:0]  HALF   = W'(1) << (FRAC_BITS - 1);
    localparam logic [HW-1:0] H_ONE  = HW'(1) << FRAC_BITS;
    localparam logic [HW-1:0] H_TWO  = H_ONE << 1;
    localparam logic [HW-1:0] H_THR  = H_TWO + H_ONE;
    localparam logic [HW-1:0] H_FOUR = H_ONE << 2;
    localparam logic [HW-1:0] H_SIX  = H_FOUR + H_TWO;

    // interpolation weight of one channel position on the hue circle
    function automatic logic [W-1:0] hue_weight(input logic [HW-1:0] t);
        logic [HW-1:0] fall;
        fall = H_FOUR - t;
        priority if (t < H_ONE) begin
            return t[W-1:0];
        end else if (t < H_THR) begin
            return ONE;
        end else if (t < H_FOUR) begin
            return fall[W-1:0];
        end else begin
            return '0;
        end
    endfunction

    logic [5:0] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    // stage a: scaled saturation and hue
    logic [W+GAIN_W-1:0] w_sp;
    logic [W+1:0]        w_scaled;
    logic [HW-1:0]       w_qh, n_h;
    logic [W-1:0]        r_a_s2, r_a_l;
    logic [HW-1:0]       r_a_h;
    logic                r_a_last;

    assign w_sp     = i_qs * i_gain;
    assign w_scaled = w_sp[W+GAIN_W-1:8];
    assign w_qh     = HW'(i_qh);

    always_comb begin
        unique case (i_sector)
            SEC_RED:   n_h = i_neg ? H_SIX - w_qh : w_qh;
            SEC_GREEN: n_h = i_neg ? H_TWO - w_qh : H_TWO + w_qh;
            SEC_BLUE:  n_h = i_neg ? H_FOUR - w_qh : H_FOUR + w_qh;
            default:   n_h = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_gray) begin
                r_a_s2 <= '0;
            end else if (w_scaled > {2'b00, ONE}) begin
                r_a_s2 <= ONE;
            end else begin
                r_a_s2 <= w_scaled[W-1:0];
            end
            r_a_h    <= n_h;
            r_a_l    <= i_l;
            r_a_last <= i_last;
        end
    end

    // stage b: l * s2 and channel weights
    logic [HW-1:0]  w_tr, w_tr_sum, w_tb;
    logic [2*W-1:0] r_b_m;
    logic [W-1:0]   r_b_s2, r_b_l;
    logic [W-1:0]   r_b_f [3];
    logic           r_b_last;

    assign w_tr_sum = r_a_h + H_TWO;
    assign w_tr     = (w_tr_sum >= H_SIX) ? w_tr_sum - H_SIX : w_tr_sum;
    assign w_tb     = (r_a_h >= H_TWO) ? r_a_h - H_TWO : r_a_h + H_FOUR;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_m    <= r_a_l * r_a_s2;
            r_b_s2   <= r_a_s2;
            r_b_l    <= r_a_l;
            r_b_f[0] <= hue_weight(w_tr);
            r_b_f[1] <= hue_weight(r_a_h);
            r_b_f[2] <= hue_weight(w_tb);
            r_b_last <= r_a_last;
        end
    end

    // stage c: q, p and their spread
    logic signed [HW-1:0] w_q, w_p, w_l2, w_diff;
    logic [W-1:0]         w_mh;
    logic signed [HW-1:0] r_c_p;
    logic [W:0]           r_c_diff;
    logic [W-1:0]         r_c_f [3];
    logic                 r_c_last;

    assign w_mh   = r_b_m[FRAC_BITS+W-1:FRAC_BITS];
    assign w_l2   = $signed(HW'({r_b_l, 1'b0}));
    assign w_q    = (r_b_l < HALF)
                  ? $signed(HW'(r_b_l)) + $signed(HW'(w_mh))
                  : $signed(HW'(r_b_l)) + $signed(HW'(r_b_s2)) - $signed(HW'(w_mh));
    assign w_p    = w_l2 - w_q;
    assign w_diff = w_q - w_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_p    <= w_p;
            r_c_diff <= w_diff[W:0];
            r_c_f    <= r_b_f;
            r_c_last <= r_b_last;
        end
    end

    // stage d: spread times weight per channel
    logic signed [HW-1:0] r_d_p;
    logic [2*W:0]         r_d_prod [3];
    logic                 r_d_last;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_d_prod[i] <= r_c_diff * r_c_f[i];
            end
            r_d_p    <= r_c_p;
            r_d_last <= r_c_last;
        end
    end

    // stage e: channel value, clamped to [0, ONE]
    logic signed [HW-1:0] w_v [3];
    logic [W-1:0]         r_e_v [3];
    logic                 r_e_last;

    for (genvar i = 0; i < 3; i++) begin : g_val
        assign w_v[i] = r_d_p + $signed(HW'(r_d_prod[i][FRAC_BITS+W:FRAC_BITS]));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                if (w_v[i] < 0) begin
                    r_e_v[i] <= '0;
                end else if (w_v[i] > $signed(HW'(ONE))) begin
                    r_e_v[i] <= ONE;
                end else begin
                    r_e_v[i] <= w_v[i][W-1:0];
                end
            end
            r_e_last <= r_d_last;
        end
    end

    // stage f: scale by 255 and drop the fraction
    logic [W+7:0] w_b [3];

    for (genvar i = 0; i < 3; i++) begin : g_byte
        assign w_b[i] = {r_e_v[i], 8'h00} - (W+8)'(r_e_v[i]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_pix.red_out   <= w_b[0][FRAC_BITS+7:FRAC_BITS];
            o_pix.green_out <= w_b[1][FRAC_BITS+7:FRAC_BITS];
            o_pix.blue_out  <= w_b[2][FRAC_BITS+7:FRAC_BITS];
            o_pix.last_out  <= r_e_last;
        end
    end

    assign o_valid = r_v[5];

endmodule

// File: design/hsl_saturation_boost.sv
// ----------------------------------------------------------------------------
// hsl_saturation_boost
// Per-pixel HSL saturation boost with an APB gain register.
// ----------------------------------------------------------------------------
// Pixels enter on the input channel (i_in_valid / o_in_ready / i_in_pixel)
// and leave on the output channel (o_out_valid / i_out_ready / o_out_pixel),
// one result per pixel, in order, with the last flag carried along.
// The gain register (unsigned Q2.8) sits at byte address 0 of the APB port;
// the user must write it only while no pixel is in flight, as the block
// itself does not enforce this. pready is always high. Pixels pass through
// three front stages, one divider stage per quotient bit (FRAC_BITS + 1),
// six back stages and the output register.
// Throughput is one pixel per cycle while the output is not stalled; the
// divider array sets the depth, not the rate.
// A synchronous reset empties the pipeline and loads the gain with 282.
// When the receiver stalls, the output register holds its transaction and
// a skid register takes one more; then o_in_ready drops and the whole
// pipeline freezes in place until the output drains.
// ----------------------------------------------------------------------------
module hsl_saturation_boost
    import hsb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_pix_in           i_in_pixel,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_pix_out          o_out_pixel,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int W      = FRAC_BITS + 1;
    localparam int DW     = FRAC_BITS + 2;
    localparam int SIDE_W = W + 5;

    // gain register
    logic [GAIN_W-1:0] r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_GAIN_IDX) begin
            r_gain <= pwdata[GAIN_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_GAIN_IDX) ? APB_DW'(r_gain) : '0;

    // global advance: stages move unless the skid register is occupied
    logic r_skid_v;
    logic w_en;

    assign w_en       = !r_skid_v;
    assign o_in_ready = w_en;

    // front end
    logic          w_fr_valid, w_fr_neg, w_fr_gray, w_fr_last;
    logic [DW-1:0] w_a0, w_b0, w_a1, w_b1;
    logic [W-1:0]  w_fr_l;
    t_sector       w_fr_sec;

    hsb_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_in_valid && w_en),
        .i_pix    (i_in_pixel),
        .o_valid  (w_fr_valid),
        .o_a0     (w_a0),
        .o_b0     (w_b0),
        .o_a1     (w_a1),
        .o_b1     (w_b1),
        .o_l      (w_fr_l),
        .o_sector (w_fr_sec),
        .o_neg    (w_fr_neg),
        .o_gray   (w_fr_gray),
        .o_last   (w_fr_last)
    );

    // divisions for saturation and hue
    logic              w_dv_valid;
    logic [W-1:0]      w_qs, w_qh;
    logic [SIDE_W-1:0] w_side_in, w_side_out;

    assign w_side_in = {w_fr_l, w_fr_sec, w_fr_neg, w_fr_gray, w_fr_last};

    hsb_div_pipe #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fr_valid),
        .i_a0    (w_a0),
        .i_b0    (w_b0),
        .i_a1    (w_a1),
        .i_b1    (w_b1),
        .i_side  (w_side_in),
        .o_valid (w_dv_valid),
        .o_q0    (w_qs),
        .o_q1    (w_qh),
        .o_side  (w_side_out)
    );

    // back end
    logic     w_bk_valid;
    t_pix_out w_bk_pix;

    hsb_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_gain   (r_gain),
        .i_valid  (w_dv_valid),
        .i_qs     (w_qs),
        .i_qh     (w_qh),
        .i_l      (w_side_out[SIDE_W-1:5]),
        .i_sector (t_sector'(w_side_out[4:3])),
        .i_neg    (w_side_out[2]),
        .i_gray   (w_side_out[1]),
        .i_last   (w_side_out[0]),
        .o_valid  (w_bk_valid),
        .o_pix    (w_bk_pix)
    );

    // output register with skid
    logic     r_out_v;
    t_pix_out r_out_pix, r_skid_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_skid_v) begin
            if (r_out_v && !i_out_ready) begin
                r_skid_v <= w_bk_valid;
            end else begin
                r_out_v <= w_bk_valid;
            end
        end else if (i_out_ready) begin
            r_out_v  <= 1'b1;
            r_skid_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            if (r_out_v && !i_out_ready) begin
                r_skid_pix <= w_bk_pix;
            end else begin
                r_out_pix <= w_bk_pix;
            end
        end else if (i_out_ready) begin
            r_out_pix <= r_skid_pix;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_pixel = r_out_pix;

endmodule

// File: design/hsb_checker.sv
// ----------------------------------------------------------------------------
// hsb_checker
// Port-level checks for hsl_saturation_boost, attached by bind.
// ----------------------------------------------------------------------------
module hsb_checker
    import hsb_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input t_pix_out          o_out_pixel,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [APB_AW-1:0] paddr,
    input logic [APB_DW-1:0] pwdata,
    input logic [APB_DW-1:0] prdata,
    input logic              pready
);

    // a stalled result holds its transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_pixel))
        else $error("output transaction changed while stalled");

    // input backpressure only with a result waiting
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result pending");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // gain write reads back
    a_gain_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && !paddr[2] ##1 !paddr[2])
        |-> prdata[GAIN_W-1:0] == $past(pwdata[GAIN_W-1:0]))
        else $error("gain register readback mismatch");

endmodule

bind hsl_saturation_boost hsb_checker u_hsb_checker (.*);

// File: dv/tb_hsl_saturation_boost.sv
// ----------------------------------------------------------------------------
// tb_hsl_saturation_boost
// Self-checking bench for the HSL saturation boost pipeline: directed and
// random pixels under several gain settings, random stalls on both sides,
// and an in-order check of every output transaction against a fixed-point
// predictor of the color conversion.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_hsl_saturation_boost;
    import hsb_pkg::*;

    localparam int  FB        = FRAC_BITS_DEF;
    localparam int  LATENCY   = FB + 11;
    localparam longint ONE    = longint'(1) << FB;
    localparam int  CYC_LIMIT = 400000;

    // saturation boost predictor and expected-pixel store
    class pixel_scoreboard;
        logic [GAIN_W-1:0] gain;
        t_pix_out          pending[$];
        int                mismatches;
        int                n_checked;

        function new();
            gain = GAIN_RESET;
            mismatches = 0;
            n_checked = 0;
        endfunction

        function longint frac_of(logic [7:0] x);
            return (longint'(x) * ONE + 254) / 255;
        endfunction

        function longint quot(longint num, longint d);
            longint mag;
            if (d <= 0) return 0;
            mag = (num < 0) ? -num : num;
            mag = (mag * ONE) / d;
            return (num < 0) ? -mag : mag;
        endfunction

        function longint hue_chan(longint p, longint q, longint t);
            longint w;
            w = t % (6 * ONE);
            if (w < 0) w += 6 * ONE;
            if (w < ONE) return p + ((q - p) * w) / ONE;
            if (w < 3 * ONE) return q;
            if (w < 4 * ONE) return p + ((q - p) * (4 * ONE - w)) / ONE;
            return p;
        endfunction

        function logic [7:0] to_byte(longint v);
            if (v < 0) v = 0;
            if (v > ONE) v = ONE;
            return 8'((v * 255) >> FB);
        endfunction

        function t_pix_out boost(t_pix_in px);
            t_pix_out r;
            longint c[3];
            longint mx, mn, d, l, s, s2, h, q, p, den;
            longint v[3];
            c[0] = frac_of(px.red_in);
            c[1] = frac_of(px.green_in);
            c[2] = frac_of(px.blue_in);
            mx = c[0]; mn = c[0];
            for (int i = 1; i < 3; i++) begin
                if (c[i] > mx) mx = c[i];
                if (c[i] < mn) mn = c[i];
            end
            l = (mx + mn) >>> 1;
            v[0] = l; v[1] = l; v[2] = l;
            // gray pixels and zero saturation keep lightness on all channels
            if (mx != mn) begin
                d = mx - mn;
                den = (l > ONE / 2) ? (2 * ONE - mx - mn) : (mx + mn);
                s = (den > 0) ? (d * ONE) / den : ONE;
                if (s > ONE) s = ONE;
                s2 = (s * longint'(gain)) >>> 8;
                if (s2 > ONE) s2 = ONE;
                if (mx == c[0]) begin
                    h = quot(c[1] - c[2], d);
                    if (c[1] < c[2]) h += 6 * ONE;
                end else if (mx == c[1]) begin
                    h = 2 * ONE + quot(c[2] - c[0], d);
                end else begin
                    h = 4 * ONE + quot(c[0] - c[1], d);
                end
                if (s2 != 0) begin
                    if (l < ONE / 2) q = (l * (ONE + s2)) / ONE;
                    else q = l + s2 - (l * s2) / ONE;
                    p = 2 * l - q;
                    v[0] = hue_chan(p, q, h + 2 * ONE);
                    v[1] = hue_chan(p, q, h);
                    v[2] = hue_chan(p, q, h - 2 * ONE);
                end
            end
            r.red_out   = to_byte(v[0]);
            r.green_out = to_byte(v[1]);
            r.blue_out  = to_byte(v[2]);
            r.last_out  = px.last_in;
            return r;
        endfunction

        function void note_pixel(t_pix_in px);
            pending.push_back(boost(px));
        endfunction

        function void check_pixel(t_pix_out got);
            t_pix_out want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output pixel %h", got);
                return;
            end
            want = pending.pop_front();
            n_checked++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("pixel %0d mismatch: exp r%0d g%0d b%0d l%0d, got r%0d g%0d b%0d l%0d",
                        n_checked, want.red_out, want.green_out, want.blue_out,
                        want.last_out, got.red_out, got.green_out, got.blue_out,
                        got.last_out);
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    t_pix_in           i_in_pixel = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_pix_out          o_out_pixel;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    pixel_scoreboard sb = new();
    int  cycle_count = 0;
    bit  calm_phase = 1'b0;
    bit  long_hold = 1'b0;
    int  n_sent = 0;

    hsl_saturation_boost DUT (.*);

    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYC_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_pixel(o_out_pixel);
    end

    // receiver with random stall bursts and one long hold-off
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold) begin
                i_out_ready <= 1'b0;
                repeat (120) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 6);
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // one input transaction, with an optional gap before it
    task automatic send_pixel(t_pix_in px);
        int n;
        if (!calm_phase && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_pixel <= px;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_pixel(px);
        n_sent++;
    endtask

    task automatic send_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
        t_pix_in px;
        px.red_in = r; px.green_in = g; px.blue_in = b; px.last_in = last;
        send_pixel(px);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // gain write over APB, pipeline idle
    task automatic write_gain(logic [GAIN_W-1:0] g);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= APB_AW'(REG_GAIN_IDX) << 2;
        pwdata <= APB_DW'(g);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
        sb.gain = g;
    endtask

    task automatic random_burst(int count);
        t_pix_in px;
        for (int k = 0; k < count; k++) begin
            px = t_pix_in'($bits(t_pix_in)'($urandom));
            // about one pixel in four made near-gray, to stress small differences
            if ($urandom_range(0, 3) == 0) begin
                px.green_in = px.red_in + 8'($urandom_range(0, 3));
                px.blue_in  = px.red_in - 8'($urandom_range(0, 3));
            end
            send_pixel(px);
        end
    endtask

    initial begin
        logic [GAIN_W-1:0] gains[6];
        gains = '{10'd282, 10'd0, 10'd1023, 10'd256, 10'd1, 10'd700};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, grays, each hue sector, ties, last flag
        send_rgb(8'd0, 8'd0, 8'd0, 1'b0);
        send_rgb(8'd255, 8'd255, 8'd255, 1'b1);
        send_rgb(8'd128, 8'd128, 8'd128, 1'b0);
        send_rgb(8'd255, 8'd0, 8'd0, 1'b0);
        send_rgb(8'd0, 8'd255, 8'd0, 1'b0);
        send_rgb(8'd0, 8'd0, 8'd255, 1'b0);
        send_rgb(8'd255, 8'd255, 8'd0, 1'b0);
        send_rgb(8'd0, 8'd255, 8'd255, 1'b0);
        send_rgb(8'd255, 8'd0, 8'd255, 1'b0);
        send_rgb(8'd200, 8'd50, 8'd100, 1'b0);
        send_rgb(8'd30, 8'd200, 8'd10, 1'b0);
        send_rgb(8'd90, 8'd40, 8'd220, 1'b0);
        send_rgb(8'd1, 8'd0, 8'd0, 1'b0);
        send_rgb(8'd255, 8'd254, 8'd254, 1'b0);
        send_rgb(8'd127, 8'd128, 8'd127, 1'b0);
        send_rgb(8'd170, 8'd85, 8'd85, 1'b1);
        drain();

        // sweep through gain settings with random pixels
        for (int gi = 0; gi < 6; gi++) begin
            write_gain(gains[gi]);
            send_rgb(8'd255, 8'd0, 8'd128, 1'b0);
            send_rgb(8'd10, 8'd20, 8'd30, 1'b1);
            if (gi == 2) begin
                // long receiver hold-off while the sender keeps offering
                long_hold = 1'b1;
                random_burst(80);
            end
            random_burst(275);
            drain();
        end

        // final stretch, no idling on either side
        calm_phase = 1'b1;
        write_gain(10'($urandom_range(0, 1023)));
        random_burst(200);
        drain();

        $display("%0d pixels sent, %0d checked, across 7 gain settings incl. 0 and 1023",
            n_sent, sb.n_checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d left over", sb.mismatches, sb.pending.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule
